### hdl/sdpg_pkg.sv
// ----------------------------------------------------------------------------
// sdpg_pkg
// Shared types and constants of the step/direction pulse generator.
// ----------------------------------------------------------------------------
package sdpg_pkg;

   // field widths
   localparam int VEL_W      = 16;
   localparam int MAG_W      = 14;   // |velocity| <= 10000
   localparam int PULSE_W    = 10;
   localparam int SETUP_W    = 10;
   localparam int MAXRATE_W  = 18;
   localparam int SPEED_W    = 25;
   localparam int PERIOD_US_W = 20;
   localparam int PROD_W     = 32;   // |v| * max_steps_per_second
   localparam int DIVIDEND_W = 34;   // holds 10^10
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // velocity limits, stop thresholds, scale factors
   localparam logic signed [VEL_W-1:0] VEL_LIMIT = 16'sd10000;
   localparam logic [MAG_W-1:0]        MIN_MAG   = 14'd50;
   localparam logic [PROD_W-1:0]       MIN_PROD  = 32'd10000;
   localparam logic [DIVIDEND_W-1:0]   PERIOD_DIVIDEND = 34'd10000000000;
   localparam logic [PROD_W-1:0]       SPEED_DIVISOR   = 32'd100;
   // x / 100 == (x * ceil(2^37 / 100)) >> 37 for any 32-bit x
   localparam logic [PROD_W-1:0]       SPEED_RECIP     = 32'h51EB851F;
   localparam int                      SPEED_SHIFT     = 37;

   // command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_PULSE_HIGH = 2'd0;
   localparam logic [1:0] REG_DIR_SETUP  = 2'd1;
   localparam logic [1:0] REG_MAX_RATE   = 2'd2;
   localparam logic [1:0] REG_INVERT_DIR = 2'd3;

   localparam logic [PULSE_W-1:0]   RST_PULSE_HIGH = 10'd5;
   localparam logic [SETUP_W-1:0]   RST_DIR_SETUP  = 10'd5;
   localparam logic [MAXRATE_W-1:0] RST_MAX_RATE   = 18'd1000;

   // item opcodes
   localparam logic OP_VELOCITY = 1'b0;
   localparam logic OP_TICK     = 1'b1;

   typedef struct packed {
      logic                    opcode;
      logic signed [VEL_W-1:0] velocity_centipercent;
   } req_type;

   typedef struct packed {
      logic                   step_level;
      logic                   dir_level;
      logic                   running;
      logic [SPEED_W-1:0]     speed_centisteps;
      logic [PERIOD_US_W-1:0] period_us;
   } rsp_type;

   // classified item as it travels through the queue
   typedef struct packed {
      logic             is_tick;
      logic             is_neg;
      logic             too_slow;   // |v| below half a percent
      logic [MAG_W-1:0] mag;
   } cmd_type;

   typedef struct packed {
      logic [PULSE_W-1:0]   pulse_high_us;
      logic [SETUP_W-1:0]   dir_setup_us;
      logic [MAXRATE_W-1:0] max_steps_per_second;
      logic                 invert_dir;
   } cfg_type;

endpackage

### hdl/sdpg_front.sv
// ----------------------------------------------------------------------------
// sdpg_front
// Input stage: accepts items, saturates velocity, splits sign and magnitude.
// ----------------------------------------------------------------------------
module sdpg_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sdpg_pkg::req_type req_data,
   output logic              push,
   output sdpg_pkg::cmd_type push_data,
   input  logic              queue_ready
);

   logic                     ent_valid_ff, ent_valid_in;
   sdpg_pkg::cmd_type        ent_ff, ent_in;
   logic signed [sdpg_pkg::VEL_W-1:0] sat;
   logic [sdpg_pkg::VEL_W-1:0]        absval;
   logic                     accept;

   assign req_ready = !ent_valid_ff || queue_ready;
   assign accept    = req_valid && req_ready;
   assign push      = ent_valid_ff;
   assign push_data = ent_ff;

   always_comb begin
      if (req_data.velocity_centipercent > sdpg_pkg::VEL_LIMIT) begin
         sat = sdpg_pkg::VEL_LIMIT;
      end else if (req_data.velocity_centipercent < -sdpg_pkg::VEL_LIMIT) begin
         sat = -sdpg_pkg::VEL_LIMIT;
      end else begin
         sat = req_data.velocity_centipercent;
      end
      absval = sat[sdpg_pkg::VEL_W-1] ? sdpg_pkg::VEL_W'(-sat) : sdpg_pkg::VEL_W'(sat);

      ent_in.is_tick  = (req_data.opcode == sdpg_pkg::OP_TICK);
      ent_in.is_neg   = sat[sdpg_pkg::VEL_W-1];
      ent_in.mag      = absval[sdpg_pkg::MAG_W-1:0];
      ent_in.too_slow = (absval[sdpg_pkg::MAG_W-1:0] < sdpg_pkg::MIN_MAG);

      ent_valid_in = accept || (ent_valid_ff && !queue_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
      end else begin
         ent_valid_ff <= ent_valid_in;
      end
      if (accept) begin
         ent_ff <= ent_in;
      end
   end

endmodule

### hdl/sdpg_queue.sv
// ----------------------------------------------------------------------------
// sdpg_queue
// Short queue of classified items between the input stage and the engine.
// ----------------------------------------------------------------------------
module sdpg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sdpg_pkg::cmd_type push_data,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output sdpg_pkg::cmd_type pop_data
);

   sdpg_pkg::cmd_type mem [sdpg_pkg::QUEUE_DEPTH];

   logic [sdpg_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sdpg_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sdpg_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push, do_pop;

   assign push_ready = (count_ff != sdpg_pkg::QCNT_W'(sdpg_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == sdpg_pkg::QPTR_W'(sdpg_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sdpg_pkg::QPTR_W'(sdpg_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/sdpg_div.sv
// ----------------------------------------------------------------------------
// sdpg_div
// Restoring divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
module sdpg_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [sdpg_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [sdpg_pkg::PROD_W-1:0]         divisor,
   output logic                                done,
   output logic [sdpg_pkg::DIVIDEND_W-1:0]     quotient
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [sdpg_pkg::DIV_CNT_W-1:0]      count_ff, count_in;
   logic [sdpg_pkg::DIVIDEND_W-1:0]     work_ff, work_in;
   logic [sdpg_pkg::PROD_W-1:0]         rem_ff, rem_in;
   logic [sdpg_pkg::PROD_W-1:0]         dsor_ff, dsor_in;
   logic [sdpg_pkg::PROD_W:0]           trial;
   logic                                ge;

   assign done     = done_ff;
   assign quotient = work_ff;

   always_comb begin
      // shift in next dividend bit, subtract if it fits
      trial   = {rem_ff, work_ff[sdpg_pkg::DIVIDEND_W-1]};
      ge      = (trial >= {1'b0, dsor_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      count_in = count_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      dsor_in = dsor_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         work_in  = dividend;
         rem_in   = '0;
         dsor_in  = divisor;
      end else if (busy_ff) begin
         rem_in   = ge ? sdpg_pkg::PROD_W'(trial - {1'b0, dsor_ff})
                       : trial[sdpg_pkg::PROD_W-1:0];
         work_in  = {work_ff[sdpg_pkg::DIVIDEND_W-2:0], ge};
         count_in = count_ff + 1'b1;
         if (count_ff == sdpg_pkg::DIV_CNT_W'(sdpg_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dsor_ff <= dsor_in;
   end

endmodule

### hdl/sdpg_back.sv
// ----------------------------------------------------------------------------
// sdpg_back
// Engine: runs ticks and velocity commands, holds the pulse state and the
// result register.
// ----------------------------------------------------------------------------
module sdpg_back #(
   parameter int PERIOD_BITS = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  sdpg_pkg::cfg_type cfg,
   input  logic              q_valid,
   input  sdpg_pkg::cmd_type q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sdpg_pkg::rsp_type rsp_data
);

   localparam int PeriodOutW = sdpg_pkg::PERIOD_US_W;
   localparam int DvdW       = sdpg_pkg::DIVIDEND_W;
   localparam int ProdWideW  = 2 * sdpg_pkg::PROD_W;
   localparam logic [PERIOD_BITS-1:0] PeriodMax = {PERIOD_BITS{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHECK,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type                        state_ff, state_in;
   logic                             run_ff, run_in;
   logic                             dir_ff, dir_in;
   logic [sdpg_pkg::SETUP_W-1:0]     setup_ff, setup_in;
   logic [PERIOD_BITS-1:0]           period_ff, period_in;
   logic [PERIOD_BITS-1:0]           phase_ff, phase_in;
   logic [sdpg_pkg::PULSE_W-1:0]     high_ff, high_in;
   logic [sdpg_pkg::SPEED_W-1:0]     speed_ff, speed_in;
   sdpg_pkg::cmd_type                cmd_ff, cmd_in;
   logic [sdpg_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic [sdpg_pkg::SPEED_W-1:0]     spd_ff, spd_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   sdpg_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic                             div_start;
   logic                             per_done;
   logic [DvdW-1:0]                  per_quot;
   logic [ProdWideW-1:0]             spd_prod;
   logic [DvdW-1:0]                  min_per, per_clamp;
   logic [PERIOD_BITS-1:0]           phase_next;
   logic                             can_emit;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;

   // 10^10 / prod for the period
   sdpg_div u_per_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sdpg_pkg::PERIOD_DIVIDEND),
      .divisor  (prod_ff),
      .done     (per_done),
      .quotient (per_quot)
   );

   // prod / 100 for the speed, by reciprocal multiply
   assign spd_prod = ProdWideW'(prod_ff) * ProdWideW'(sdpg_pkg::SPEED_RECIP);

   always_comb begin
      state_in     = state_ff;
      run_in       = run_ff;
      dir_in       = dir_ff;
      setup_in     = setup_ff;
      period_in    = period_ff;
      phase_in     = phase_ff;
      high_in      = high_ff;
      speed_in     = speed_ff;
      cmd_in       = cmd_ff;
      prod_in      = prod_ff;
      spd_in       = spd_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      phase_next   = phase_ff + 1'b1;

      min_per   = DvdW'(cfg.pulse_high_us) + DvdW'(2);
      per_clamp = (per_quot < min_per) ? min_per : per_quot;
      if (per_clamp > DvdW'(PeriodMax)) begin
         per_clamp = DvdW'(PeriodMax);
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cmd_in = q_data;
               if (q_data.is_tick) begin
                  if (high_ff != '0) begin
                     high_in = high_ff - 1'b1;
                  end
                  if (run_ff) begin
                     if (setup_ff != '0) begin
                        setup_in = setup_ff - 1'b1;
                     end else if (phase_next >= period_ff) begin
                        phase_in = '0;
                        high_in  = cfg.pulse_high_us;
                     end else begin
                        phase_in = phase_next;
                     end
                  end
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = sdpg_pkg::PROD_W'(cmd_ff.mag) *
                       sdpg_pkg::PROD_W'(cfg.max_steps_per_second);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // every command stops first; a stop command keeps the direction level
            run_in    = 1'b0;
            setup_in  = '0;
            period_in = '0;
            phase_in  = '0;
            speed_in  = '0;
            if (cmd_ff.too_slow || prod_ff < sdpg_pkg::MIN_PROD) begin
               state_in = ST_EMIT;
            end else begin
               dir_in    = cmd_ff.is_neg ^ cfg.invert_dir;
               spd_in    = spd_prod[sdpg_pkg::SPEED_SHIFT +: sdpg_pkg::SPEED_W];
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (per_done) begin
               period_in = per_clamp[PERIOD_BITS-1:0];
               speed_in  = spd_ff;
               setup_in  = cfg.dir_setup_us;
               phase_in  = '0;
               run_in    = 1'b1;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (can_emit) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.step_level       = (high_ff != '0);
               rsp_data_in.dir_level        = dir_ff;
               rsp_data_in.running          = run_ff;
               rsp_data_in.speed_centisteps = speed_ff;
               rsp_data_in.period_us        = PeriodOutW'(period_ff);
               state_in                     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_ff       <= 1'b0;
         dir_ff       <= 1'b0;
         setup_ff     <= '0;
         period_ff    <= '0;
         phase_ff     <= '0;
         high_ff      <= '0;
         speed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         dir_ff       <= dir_in;
         setup_ff     <= setup_in;
         period_ff    <= period_in;
         phase_ff     <= phase_in;
         high_ff      <= high_in;
         speed_ff     <= speed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      prod_ff     <= prod_in;
      spd_ff      <= spd_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### hdl/step_dir_pulse_generator.sv
// ----------------------------------------------------------------------------
// step_dir_pulse_generator
// Step/direction pulse generator for a stepper driver, driven by velocity
// commands and one-microsecond tick words.
// ----------------------------------------------------------------------------
// Every request word produces exactly one response word with the output levels
// after that word. A velocity command takes one multiply of |v| by
// max_steps_per_second, then a 34-step bit-serial divide (10^10 / product for
// the period; the speed, product / 100, comes from a reciprocal multiply while
// the divide starts), then the update. A two-entry queue sits between the
// input stage and the engine, so requests are still taken while a command
// divides or a response waits, until the queue and the input register are
// full. Registers (APB, 32-bit data): 0x0 pulse_high_us, 0x4 dir_setup_us,
// 0x8 max_steps_per_second, 0xC invert_dir. Write them only while no word is
// in flight.
// ----------------------------------------------------------------------------
module step_dir_pulse_generator #(
   parameter int PERIOD_BITS = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   // request words
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sdpg_pkg::req_type                   req_data,
   // response words
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sdpg_pkg::rsp_type                   rsp_data,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sdpg_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sdpg_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sdpg_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   sdpg_pkg::cfg_type cfg_ff, cfg_in;
   logic              csr_wr;
   logic              push, push_ready, pop, pop_valid;
   sdpg_pkg::cmd_type push_data, pop_data;

   // ---- register file ------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            sdpg_pkg::REG_PULSE_HIGH:
               cfg_in.pulse_high_us = csr_pwdata[sdpg_pkg::PULSE_W-1:0];
            sdpg_pkg::REG_DIR_SETUP:
               cfg_in.dir_setup_us = csr_pwdata[sdpg_pkg::SETUP_W-1:0];
            sdpg_pkg::REG_MAX_RATE:
               cfg_in.max_steps_per_second = csr_pwdata[sdpg_pkg::MAXRATE_W-1:0];
            sdpg_pkg::REG_INVERT_DIR:
               cfg_in.invert_dir = csr_pwdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // read mux
   always_comb begin
      case (csr_paddr[3:2])
         sdpg_pkg::REG_PULSE_HIGH:
            csr_prdata = sdpg_pkg::CSR_DATA_W'(cfg_ff.pulse_high_us);
         sdpg_pkg::REG_DIR_SETUP:
            csr_prdata = sdpg_pkg::CSR_DATA_W'(cfg_ff.dir_setup_us);
         sdpg_pkg::REG_MAX_RATE:
            csr_prdata = sdpg_pkg::CSR_DATA_W'(cfg_ff.max_steps_per_second);
         sdpg_pkg::REG_INVERT_DIR:
            csr_prdata = sdpg_pkg::CSR_DATA_W'(cfg_ff.invert_dir);
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_high_us        <= sdpg_pkg::RST_PULSE_HIGH;
         cfg_ff.dir_setup_us         <= sdpg_pkg::RST_DIR_SETUP;
         cfg_ff.max_steps_per_second <= sdpg_pkg::RST_MAX_RATE;
         cfg_ff.invert_dir           <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- input stage: saturate and classify ---------------------------------
   sdpg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .push        (push),
      .push_data   (push_data),
      .queue_ready (push_ready)
   );

   // ---- decoupling queue ---------------------------------------------------
   sdpg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   // ---- engine: ticks, command math, response register ---------------------
   sdpg_back #(
      .PERIOD_BITS (PERIOD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (pop_valid),
      .q_data    (pop_data),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
